// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/tls_pkg.sv =====
// Types and constants of the text line scanner.
`default_nettype none

package tls_pkg;

   localparam int BYTE_W     = 8;
   localparam int LINE_W     = 41;
   localparam int CNT_W      = 25;
   localparam int SPACE_W    = 33;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 33;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LINE_BYTES = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANCHOR_SPACING = 1'd1;

   localparam logic [CNT_W-1:0]   RESET_MAX_LINE = 25'd65536;
   localparam logic [SPACE_W-1:0] RESET_SPACING  = 33'd65536;

   // Byte codes
   localparam logic [BYTE_W-1:0] BYTE_LF = 8'h0A;
   localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0D;
   localparam logic [BYTE_W-1:0] BYTE_EF = 8'hEF;
   localparam logic [BYTE_W-1:0] BYTE_BB = 8'hBB;
   localparam logic [BYTE_W-1:0] BYTE_BF = 8'hBF;

   // Result kinds
   localparam logic KIND_ANCHOR = 1'b0;
   localparam logic KIND_TOTALS = 1'b1;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              is_last;
   } req_type;

   typedef struct packed {
      logic              result_kind;
      logic [LINE_W-1:0] line_number;
      logic [LINE_W-1:0] byte_offset;
      logic [CNT_W-1:0]  longest_line_cols;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/tls_req_if.sv =====
// Byte input channel of the scanner.
`default_nettype none

interface tls_req_if import tls_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              is_last;

   modport source (output valid, output data_byte, output is_last, input ready);
   modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/tls_rsp_if.sv =====
// Result channel of the scanner.
`default_nettype none

interface tls_rsp_if import tls_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              result_kind;
   logic [LINE_W-1:0] line_number;
   logic [LINE_W-1:0] byte_offset;
   logic [CNT_W-1:0]  longest_line_cols;

   modport source (output valid, output result_kind, output line_number,
                   output byte_offset, output longest_line_cols, input ready);
   modport sink   (input valid, input result_kind, input line_number,
                   input byte_offset, input longest_line_cols, output ready);
endinterface

`default_nettype wire

// ===== rtl/tls_in_buf.sv =====
// Two-entry input buffer that registers incoming byte beats.
`default_nettype none
`include "assert_macros.svh"

module tls_in_buf import tls_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   tls_req_if.sink      req_ch,
   output req_type      head_data,
   output logic         head_valid,
   input  wire logic    head_pop
);

   req_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   // Accept while a slot is free; no path from the result side
   assign req_ch.ready = (count_ff != 2'd2);
   assign push         = req_ch.valid && req_ch.ready;
   assign head_valid   = (count_ff != 2'd0);
   assign head_data    = slot_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = head_pop ? ~rd_ptr_ff : rd_ptr_ff;
      unique case ({push, head_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the beat payload
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{data_byte: req_ch.data_byte, is_last: req_ch.is_last};
      end
   end

   `ASSERT_ALWAYS(a_count_range, clock, reset, count_ff != 2'd3)
   `ASSERT_IMPLIES(a_pop_nonempty, clock, reset, head_pop, count_ff != 2'd0)

endmodule

`default_nettype wire

// ===== rtl/tls_core.sv =====
// Scan state, configuration registers and per-byte update logic.
`default_nettype none
`include "assert_macros.svh"

module tls_core import tls_pkg::*; #(
   parameter int OFFSET_WIDTH = 40
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  head_valid,
   input  req_type                    head_data,
   input  wire logic                  out_free,
   output logic                       head_pop,
   output logic                       res_valid,
   output rsp_type                    res_data
);

   localparam int PW    = OFFSET_WIDTH + 1;
   localparam int CMP_W = (PW > SPACE_W) ? PW : SPACE_W;
   localparam logic [PW-1:0] CAP   = {1'b1, {OFFSET_WIDTH{1'b0}}};
   localparam logic [PW-1:0] ONE   = PW'(1);
   localparam logic [PW-1:0] TWO   = PW'(2);
   localparam logic [PW-1:0] THREE = PW'(3);
   localparam logic [CNT_W-1:0] CNT_ONE = 25'd1;
   localparam logic [CNT_W-1:0] CNT_TWO = 25'd2;

   // Byte order mark tracking
   localparam logic [2:0] MARK_WAIT  = 3'd0;
   localparam logic [2:0] MARK_EF    = 3'd1;
   localparam logic [2:0] MARK_EFBB  = 3'd2;
   localparam logic [2:0] MARK_PLAIN = 3'd3;
   localparam logic [2:0] MARK_SKIP  = 3'd4;

   function automatic logic [PW-1:0] sat_off(input logic [PW-1:0] v);
      return (v < CAP) ? v + ONE : CAP;
   endfunction

   function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] v);
      return (v != '1) ? v + CNT_ONE : v;
   endfunction

   // Configuration registers
   logic [CNT_W-1:0]   max_ff;
   logic [SPACE_W-1:0] spacing_ff;

   // Scan state
   logic [2:0]        mark_ff, mark_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [PW-1:0]     line_ff, line_in;
   logic [PW-1:0]     start_ff, start_in;
   logic [PW-1:0]     anchor_ff, anchor_in;
   logic [CNT_W-1:0]  lbc_ff, lbc_in;
   logic [CNT_W-1:0]  col_ff, col_in;
   logic [CNT_W-1:0]  longest_ff, longest_in;
   logic              pend_ff, pend_in;
   logic [BYTE_W-1:0] prev_ff, prev_in;

   // Working values
   logic [BYTE_W-1:0] byte_v;
   logic              last_v, is_cont, max_nz, max_ge2;
   logic [PW-1:0]     p_pos, s_pos, s_line, s_start, s_anchor, fin_lines, gap;
   logic [CNT_W-1:0]  p_lbc, p_col, s_lbc, s_col, s_long, col_adj, fin_long;
   logic              p_pend, s_pend, anchor_hit, fin_tail, do_clear, emit;
   logic [BYTE_W-1:0] p_prev;
   logic [2:0]        scan_mark;
   logic              res_kind;
   logic [PW-1:0]     res_line, res_off;
   logic [CNT_W-1:0]  res_long;

   // Pop a byte unless its result would land on a held one
   assign head_pop  = head_valid && (out_free || !emit);
   assign res_valid = head_pop && emit;
   assign res_data  = '{result_kind:       res_kind,
                        line_number:       LINE_W'(res_line),
                        byte_offset:       LINE_W'(res_off),
                        longest_line_cols: res_long};

   always_comb begin
      byte_v  = head_data.data_byte;
      last_v  = head_data.is_last;
      max_nz  = (max_ff != '0);
      max_ge2 = (max_ff >= CNT_TWO);
      is_cont = (byte_v[7:6] == 2'b10);

      // State ahead of the current byte, with held mark bytes folded in
      p_pos  = pos_ff;
      p_lbc  = lbc_ff;
      p_col  = col_ff;
      p_pend = pend_ff;
      p_prev = prev_ff;
      unique case (mark_ff)
         MARK_EF: begin
            p_pos  = ONE;
            p_lbc  = CNT_ONE;
            p_col  = CNT_W'(max_nz);
            p_pend = max_nz;
            p_prev = BYTE_EF;
         end
         MARK_EFBB: begin
            p_pos  = TWO;
            p_lbc  = CNT_TWO;
            p_col  = CNT_W'(max_ge2);
            p_pend = max_ge2;
            p_prev = BYTE_BB;
         end
         default: ;
      endcase
      scan_mark = (mark_ff == MARK_SKIP) ? MARK_SKIP : MARK_PLAIN;

      // Scan the current byte
      s_pos      = sat_off(p_pos);
      s_line     = line_ff;
      s_start    = start_ff;
      s_anchor   = anchor_ff;
      s_long     = longest_ff;
      s_lbc      = p_lbc;
      s_col      = p_col;
      s_pend     = p_pend;
      col_adj    = p_col;
      gap        = s_pos - anchor_ff;
      anchor_hit = 1'b0;
      if (byte_v == BYTE_LF) begin
         // Drop a CR that ends the counted part of the line
         if (p_col != '0 && p_lbc <= max_ff && p_prev == BYTE_CR) begin
            col_adj = p_col - CNT_ONE;
         end
         s_long  = (col_adj > longest_ff) ? col_adj : longest_ff;
         s_lbc   = '0;
         s_col   = '0;
         s_pend  = 1'b0;
         s_line  = sat_off(line_ff);
         s_start = s_pos;
         anchor_hit = !last_v && (s_pos >= anchor_ff) &&
                      (CMP_W'(gap) >= CMP_W'(spacing_ff));
         if (anchor_hit) begin
            s_anchor = s_pos;
         end
      end else begin
         if (p_lbc < max_ff) begin
            if (!is_cont) begin
               s_col  = sat_cnt(p_col);
               s_pend = (byte_v >= 8'hC0);
            end
         end else if (p_lbc == max_ff && is_cont && p_pend) begin
            // Take back a lead byte whose sequence the limit cuts
            if (p_col != '0) begin
               s_col = p_col - CNT_ONE;
            end
            s_pend = 1'b0;
         end
         s_lbc = sat_cnt(p_lbc);
      end

      // Totals when this byte ends the file
      fin_tail  = (s_start < s_pos);
      fin_lines = fin_tail ? sat_off(s_line) : s_line;
      fin_long  = (fin_tail && s_col > s_long) ? s_col : s_long;

      // Hold by default
      mark_in    = mark_ff;
      pos_in     = pos_ff;
      line_in    = line_ff;
      start_in   = start_ff;
      anchor_in  = anchor_ff;
      lbc_in     = lbc_ff;
      col_in     = col_ff;
      longest_in = longest_ff;
      pend_in    = pend_ff;
      prev_in    = prev_ff;
      do_clear   = 1'b0;
      emit       = 1'b0;
      res_kind   = KIND_ANCHOR;
      res_line   = s_line;
      res_off    = s_pos;
      res_long   = s_long;

      priority if (mark_ff == MARK_WAIT && byte_v == BYTE_EF && !last_v) begin
         mark_in = MARK_EF;
      end else if (mark_ff == MARK_EF && byte_v == BYTE_BB && !last_v) begin
         mark_in = MARK_EFBB;
      end else if (mark_ff == MARK_EFBB && byte_v == BYTE_BF) begin
         // Full mark: content starts at offset three
         if (last_v) begin
            emit     = 1'b1;
            do_clear = 1'b1;
            res_kind = KIND_TOTALS;
            res_line = '0;
            res_off  = THREE;
            res_long = longest_ff;
         end else begin
            mark_in   = MARK_SKIP;
            pos_in    = THREE;
            start_in  = THREE;
            anchor_in = THREE;
            prev_in   = BYTE_BF;
         end
      end else if (last_v) begin
         emit     = 1'b1;
         do_clear = 1'b1;
         res_kind = KIND_TOTALS;
         res_line = fin_lines;
         res_off  = (scan_mark == MARK_SKIP) ? THREE : '0;
         res_long = fin_long;
      end else begin
         mark_in    = scan_mark;
         pos_in     = s_pos;
         line_in    = s_line;
         start_in   = s_start;
         anchor_in  = s_anchor;
         lbc_in     = s_lbc;
         col_in     = s_col;
         longest_in = s_long;
         pend_in    = s_pend;
         prev_in    = byte_v;
         emit       = anchor_hit;
      end

      // Start a fresh file after the totals
      if (do_clear) begin
         mark_in    = MARK_WAIT;
         pos_in     = '0;
         line_in    = '0;
         start_in   = '0;
         anchor_in  = '0;
         lbc_in     = '0;
         col_in     = '0;
         longest_in = '0;
         pend_in    = 1'b0;
         prev_in    = '0;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff     <= RESET_MAX_LINE;
         spacing_ff <= RESET_SPACING;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_LINE_BYTES: max_ff     <= csr_wdata[CNT_W-1:0];
            CSR_ANCHOR_SPACING: spacing_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Advance scan state on each consumed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff    <= MARK_WAIT;
         pos_ff     <= '0;
         line_ff    <= '0;
         start_ff   <= '0;
         anchor_ff  <= '0;
         lbc_ff     <= '0;
         col_ff     <= '0;
         longest_ff <= '0;
         pend_ff    <= 1'b0;
         prev_ff    <= '0;
      end else if (head_pop) begin
         mark_ff    <= mark_in;
         pos_ff     <= pos_in;
         line_ff    <= line_in;
         start_ff   <= start_in;
         anchor_ff  <= anchor_in;
         lbc_ff     <= lbc_in;
         col_ff     <= col_in;
         longest_ff <= longest_in;
         pend_ff    <= pend_in;
         prev_ff    <= prev_in;
      end
   end

   `ASSERT_ALWAYS(a_offsets_capped, clock, reset, pos_ff <= CAP && line_ff <= CAP)
   `ASSERT_NEXT(a_totals_clear, clock, reset,
                res_valid && res_kind == KIND_TOTALS,
                pos_ff == '0 && mark_ff == MARK_WAIT)
   `ASSERT_NEXT(a_anchor_at_start, clock, reset,
                res_valid && res_kind == KIND_ANCHOR, anchor_ff == start_ff)

endmodule

`default_nettype wire

// ===== rtl/tls_out_reg.sv =====
// Result register that holds a beat until the consumer takes it.
`default_nettype none
`include "assert_macros.svh"

module tls_out_reg import tls_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic res_valid,
   input  rsp_type   res_data,
   output logic      out_free,
   tls_rsp_if.source rsp_ch
);

   logic    valid_ff;
   rsp_type data_ff;

   assign out_free                 = !valid_ff || rsp_ch.ready;
   assign rsp_ch.valid             = valid_ff;
   assign rsp_ch.result_kind       = data_ff.result_kind;
   assign rsp_ch.line_number       = data_ff.line_number;
   assign rsp_ch.byte_offset       = data_ff.byte_offset;
   assign rsp_ch.longest_line_cols = data_ff.longest_line_cols;

   // Load a new result or drop the one taken
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (res_valid) begin
         valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         data_ff <= res_data;
      end
   end

   `ASSERT_IMPLIES(a_no_overwrite, clock, reset, res_valid, !valid_ff || rsp_ch.ready)

endmodule

`default_nettype wire

// ===== rtl/text_line_scanner.sv =====
// Top level of the text line scanner.
//
//   channel   dir  beat contents                                    handshake
//   req_ch    in   data_byte, is_last                               valid/ready
//   rsp_ch    out  result_kind, line_number, byte_offset,           valid/ready
//                  longest_line_cols
//   csr_*     in   csr_index, csr_wdata                             csr_we
//
// One byte per clock: each byte is taken from a two-entry input buffer and
// updates the registered scan counters as it is popped; the result register follows.
// A result is loaded into the result register once its byte leaves the input buffer.
// A held result stalls scanning only when the byte would produce another one;
// the input stalls once both buffer entries are full.
// Synchronous reset restores the register defaults and starts a new file.
`default_nettype none

module text_line_scanner import tls_pkg::*; #(
   parameter int OFFSET_WIDTH = 40
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   tls_req_if.sink                    req_ch,
   tls_rsp_if.source                  rsp_ch
);

   req_type head_data;
   logic    head_valid;
   logic    head_pop;
   logic    out_free;
   logic    res_valid;
   rsp_type res_data;

   tls_in_buf u_in_buf (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .head_data  (head_data),
      .head_valid (head_valid),
      .head_pop   (head_pop)
   );

   tls_core #(
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .head_valid (head_valid),
      .head_data  (head_data),
      .out_free   (out_free),
      .head_pop   (head_pop),
      .res_valid  (res_valid),
      .res_data   (res_data)
   );

   tls_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_data  (res_data),
      .out_free  (out_free),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== tb/sv/text_line_scanner_test.sv =====
// Self-checking testbench of the text line scanner: directed bytes, random files, register sweeps.
`default_nettype none

module text_line_scanner_test;
   import tls_pkg::*;

   localparam int          HALF_PERIOD   = 10;
   localparam int          RESET_CYCLES  = 10;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          HOLD_CYCLES   = 400;
   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          PRINT_LIMIT   = 100;
   localparam logic [40:0] OFF_CAP       = 41'h100_0000_0000;
   localparam logic [24:0] COUNT_CAP     = 25'h1FF_FFFF;

   typedef enum logic [2:0] {
      MARK_WAIT, MARK_SAW_EF, MARK_SAW_EFBB, MARK_NONE, MARK_FOUND
   } mark_stage_type;

   // One directed beat; want holds a result typed in by hand when typed is set
   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              is_last;
      logic              typed;
      rsp_type           want;
   } script_row_type;

   localparam int SCRIPT_LEN = 23;
   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      // mark only
      '{BYTE_EF, 1'b0, 1'b0, '0},
      '{BYTE_BB, 1'b0, 1'b0, '0},
      '{BYTE_BF, 1'b1, 1'b1, '{KIND_TOTALS, 41'd0, 41'd3, 25'd0}},
      // one byte files
      '{8'h41, 1'b1, 1'b1, '{KIND_TOTALS, 41'd1, 41'd0, 25'd1}},
      '{8'h00, 1'b1, 1'b1, '{KIND_TOTALS, 41'd1, 41'd0, 25'd1}},
      '{8'hFF, 1'b1, 1'b1, '{KIND_TOTALS, 41'd1, 41'd0, 25'd1}},
      // partial mark, then a short file ending inside the mark
      '{BYTE_EF, 1'b0, 1'b0, '0},
      '{BYTE_LF, 1'b1, 1'b0, '0},
      '{BYTE_EF, 1'b0, 1'b0, '0},
      '{BYTE_BB, 1'b1, 1'b0, '0},
      // marked file: three byte sequence, CR LF, extremes of the byte
      '{BYTE_EF, 1'b0, 1'b0, '0},
      '{BYTE_BB, 1'b0, 1'b0, '0},
      '{BYTE_BF, 1'b0, 1'b0, '0},
      '{8'hE2,   1'b0, 1'b0, '0},
      '{8'h82,   1'b0, 1'b0, '0},
      '{8'hAC,   1'b0, 1'b0, '0},
      '{BYTE_CR, 1'b0, 1'b0, '0},
      '{BYTE_LF, 1'b0, 1'b0, '0},
      '{8'h00,   1'b0, 1'b0, '0},
      '{8'hFF,   1'b0, 1'b0, '0},
      '{8'h80,   1'b0, 1'b0, '0},
      '{8'h7F,   1'b1, 1'b0, '0},
      // lone LF file
      '{BYTE_LF, 1'b1, 1'b1, '{KIND_TOTALS, 41'd1, 41'd0, 25'd0}}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tls_req_if req_if ();
   tls_rsp_if rsp_if ();

   text_line_scanner uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if)
   );

   always #HALF_PERIOD clock = ~clock;

   // Predicted scanner state and register copies
   logic [CNT_W-1:0]   cfg_max_line = RESET_MAX_LINE;
   logic [SPACE_W-1:0] cfg_spacing  = RESET_SPACING;
   mark_stage_type     mark_stage;
   logic [40:0]        scan_pos, line_idx, line_begin, anchor_at;
   logic [24:0]        line_bytes, line_cols, widest_cols;
   logic               cut_lead;
   logic [7:0]         prior_byte;

   rsp_type pending_results [$];

   int  mismatches, results_seen, anchors_seen, totals_seen;
   int  bytes_sent, files_sent, settings_used;
   int  cycle_count;
   bit  calm, hold_request, hold_taken;

   function automatic logic [40:0] bump_offset(logic [40:0] v);
      return (v < OFF_CAP) ? v + 41'd1 : OFF_CAP;
   endfunction

   function automatic logic [24:0] bump_count(logic [24:0] v);
      return (v != COUNT_CAP) ? v + 25'd1 : v;
   endfunction

   // Append a predicted result behind the ones already waiting
   function automatic void queue_result(rsp_type r);
      pending_results.insert(pending_results.size(), r);
   endfunction

   // Append one byte to a file under construction
   function automatic void append_byte(ref logic [7:0] fq[$], input logic [7:0] b);
      fq.insert(fq.size(), b);
   endfunction

   function automatic void clear_scan();
      mark_stage  = MARK_WAIT;
      scan_pos    = '0;
      line_idx    = '0;
      line_begin  = '0;
      line_bytes  = '0;
      line_cols   = '0;
      cut_lead    = 1'b0;
      widest_cols = '0;
      anchor_at   = '0;
      prior_byte  = '0;
   endfunction

   // Advance the line counters by one content byte; queue an anchor if one is due
   function automatic void scan_content(logic [7:0] b, logic last);
      rsp_type r;
      logic    cont;
      scan_pos = bump_offset(scan_pos);
      if (b == BYTE_LF) begin
         // drop the CR of a CR LF pair if it was counted
         if (line_cols != 0 && line_bytes <= cfg_max_line && prior_byte == BYTE_CR)
            line_cols = line_cols - 25'd1;
         if (line_cols > widest_cols)
            widest_cols = line_cols;
         line_bytes = '0;
         line_cols  = '0;
         cut_lead   = 1'b0;
         line_idx   = bump_offset(line_idx);
         line_begin = scan_pos;
         if (!last && scan_pos >= anchor_at &&
             (scan_pos - anchor_at) >= {8'd0, cfg_spacing}) begin
            anchor_at           = scan_pos;
            r.result_kind       = KIND_ANCHOR;
            r.line_number       = line_idx;
            r.byte_offset       = scan_pos;
            r.longest_line_cols = widest_cols;
            queue_result(r);
         end
      end else begin
         cont = (b[7:6] == 2'b10);
         if (line_bytes < cfg_max_line) begin
            if (!cont) begin
               line_cols = bump_count(line_cols);
               cut_lead  = (b >= 8'hC0);
            end
         end else if (line_bytes == cfg_max_line && cont && cut_lead) begin
            // the limit cut a multi-byte sequence: take its lead back out
            if (line_cols != 0)
               line_cols = line_cols - 25'd1;
            cut_lead = 1'b0;
         end
         line_bytes = bump_count(line_bytes);
      end
      prior_byte = b;
   endfunction

   // Queue the file totals and start over
   function automatic void close_file();
      rsp_type r;
      r.result_kind = KIND_TOTALS;
      r.line_number = line_idx;
      r.byte_offset = (mark_stage == MARK_FOUND) ? 41'd3 : 41'd0;
      if (line_begin < scan_pos) begin
         if (line_cols > widest_cols)
            widest_cols = line_cols;
         r.line_number = bump_offset(line_idx);
      end
      r.longest_line_cols = widest_cols;
      queue_result(r);
      clear_scan();
   endfunction

   function automatic void predict_byte(logic [7:0] b, logic last);
      mark_stage_type held;
      if (mark_stage == MARK_WAIT && b == BYTE_EF && !last) begin
         mark_stage = MARK_SAW_EF;
         return;
      end
      if (mark_stage == MARK_SAW_EF && b == BYTE_BB && !last) begin
         mark_stage = MARK_SAW_EFBB;
         return;
      end
      if (mark_stage == MARK_SAW_EFBB && b == BYTE_BF) begin
         mark_stage = MARK_FOUND;
         scan_pos   = 41'd3;
         line_begin = 41'd3;
         anchor_at  = 41'd3;
         prior_byte = BYTE_BF;
         if (last)
            close_file();
         return;
      end
      // a broken mark: scan the held bytes as content first
      if (mark_stage <= MARK_SAW_EFBB) begin
         held       = mark_stage;
         mark_stage = MARK_NONE;
         if (held >= MARK_SAW_EF)
            scan_content(BYTE_EF, 1'b0);
         if (held >= MARK_SAW_EFBB)
            scan_content(BYTE_BB, 1'b0);
      end
      scan_content(b, last);
      if (last)
         close_file();
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("MISMATCH at result %0d, %s: got %0h, want %0h",
                  results_seen, field, got, want);
   endtask

   // Offer one beat, sometimes with a random gap ahead of it, and predict once it is taken
   task automatic send_byte(input logic [7:0] b, input logic last);
      if (!calm && $urandom_range(0, 9) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      req_if.is_last   <= last;
      do @(posedge clock); while (!req_if.ready);
      predict_byte(b, last);
      bytes_sent++;
   endtask

   // Wait until every predicted result is out and the pipeline has drained
   task automatic settle();
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [CSR_DATA_W-1:0] max_line,
                                input logic [CSR_DATA_W-1:0] spacing);
      csr_we    <= 1'b1;
      csr_index <= CSR_MAX_LINE_BYTES;
      csr_wdata <= max_line;
      @(posedge clock);
      csr_index <= CSR_ANCHOR_SPACING;
      csr_wdata <= spacing;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      cfg_max_line = max_line[CNT_W-1:0];
      cfg_spacing  = spacing[SPACE_W-1:0];
      settings_used++;
   endtask

   // Build a random file: mostly UTF-8 lines, some with a mark, some plain noise
   function automatic void build_text(ref logic [7:0] fq[$]);
      int pick, lines, points, kind;
      fq.delete();
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
         append_byte(fq, BYTE_EF);
         append_byte(fq, BYTE_BB);
         append_byte(fq, BYTE_BF);
      end else if (pick == 4) begin
         append_byte(fq, BYTE_EF);
      end else if (pick == 5) begin
         append_byte(fq, BYTE_EF);
         append_byte(fq, BYTE_BB);
      end
      if ($urandom_range(0, 6) == 0) begin
         repeat ($urandom_range(1, 40))
            append_byte(fq, ($urandom_range(0, 3) == 0) ?
                            BYTE_LF : 8'($urandom_range(0, 255)));
      end else begin
         lines = $urandom_range(1, 6);
         repeat (lines) begin
            points = $urandom_range(0, 8);
            repeat (points) begin
               kind = $urandom_range(0, 9);
               case (kind)
                  0, 1, 2, 3: append_byte(fq, 8'($urandom_range(8'h20, 8'h7E)));
                  4, 5: begin
                     append_byte(fq, 8'($urandom_range(8'hC2, 8'hDF)));
                     append_byte(fq, 8'h80 | 8'($urandom_range(0, 63)));
                  end
                  6: begin
                     append_byte(fq, 8'($urandom_range(8'hE0, 8'hEF)));
                     repeat (2) append_byte(fq, 8'h80 | 8'($urandom_range(0, 63)));
                  end
                  7: begin
                     append_byte(fq, 8'($urandom_range(8'hF0, 8'hF4)));
                     repeat (3) append_byte(fq, 8'h80 | 8'($urandom_range(0, 63)));
                  end
                  8: append_byte(fq, 8'h80 | 8'($urandom_range(0, 63)));
                  default: append_byte(fq, BYTE_CR);
               endcase
            end
            kind = $urandom_range(0, 5);
            if (kind <= 2) begin
               append_byte(fq, BYTE_LF);
            end else if (kind <= 4) begin
               append_byte(fq, BYTE_CR);
               append_byte(fq, BYTE_LF);
            end
         end
      end
      if (fq.size() == 0)
         append_byte(fq, 8'($urandom_range(0, 255)));
   endfunction

   task automatic send_file(ref logic [7:0] fq[$]);
      foreach (fq[i])
         send_byte(fq[i], i == fq.size() - 1);
      files_sent++;
   endtask

   task automatic run_files(input int nbytes);
      logic [7:0] fq[$];
      int         start;
      start = bytes_sent;
      while (bytes_sent - start < nbytes) begin
         build_text(fq);
         send_file(fq);
      end
      settle();
   endtask

   // Receiver: random back-pressure, one long hold-off on request, and the checks
   initial begin : receiver
      rsp_type got, want;
      int      gap_left, hold_left;
      gap_left  = 0;
      hold_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            got.result_kind       = rsp_if.result_kind;
            got.line_number       = rsp_if.line_number;
            got.byte_offset       = rsp_if.byte_offset;
            got.longest_line_cols = rsp_if.longest_line_cols;
            results_seen++;
            if (got.result_kind == KIND_ANCHOR)
               anchors_seen++;
            else
               totals_seen++;
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected beat", 64'(got.line_number), 64'd0);
            end else begin
               want = pending_results.pop_front();
               if (got.result_kind != want.result_kind)
                  report_mismatch("result_kind", 64'(got.result_kind),
                                  64'(want.result_kind));
               if (got.line_number != want.line_number)
                  report_mismatch("line_number", 64'(got.line_number),
                                  64'(want.line_number));
               if (got.byte_offset != want.byte_offset)
                  report_mismatch("byte_offset", 64'(got.byte_offset),
                                  64'(want.byte_offset));
               if (got.longest_line_cols != want.longest_line_cols)
                  report_mismatch("longest_line_cols", 64'(got.longest_line_cols),
                                  64'(want.longest_line_cols));
            end
         end
         // pick ready for the next edge
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES - 1;
            rsp_if.ready <= 1'b0;
         end else if (gap_left != 0) begin
            gap_left--;
            rsp_if.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(1, 17) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : stimulus
      logic [7:0] fq[$];
      req_if.valid     = 1'b0;
      req_if.data_byte = '0;
      req_if.is_last   = 1'b0;
      csr_we           = 1'b0;
      csr_index        = CSR_MAX_LINE_BYTES;
      csr_wdata        = '0;
      clear_scan();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats under the reset register values
      settings_used = 1;
      for (int i = 0; i < SCRIPT_LEN; i++) begin
         send_byte(SCRIPT[i].data_byte, SCRIPT[i].is_last);
         if (SCRIPT[i].typed)
            pending_results[pending_results.size() - 1] = SCRIPT[i].want;
         if (SCRIPT[i].is_last)
            files_sent++;
      end
      settle();
      run_files(150);

      // Sweep the registers, extremes and zero included
      apply_setting(33'd4, 33'd0);
      run_files(200);
      apply_setting(33'd1, 33'd1);
      run_files(170);
      apply_setting(33'd0, 33'd7);
      run_files(150);
      apply_setting(33'h100_0000, 33'h1_0000_0000);
      run_files(150);

      // Hold off the receiver while LF-heavy files back up the input
      apply_setting(33'd5, 33'd0);
      hold_request = 1'b1;
      repeat (2) begin
         fq.delete();
         repeat (80)
            append_byte(fq, ($urandom_range(0, 2) == 0) ? 8'h61 : BYTE_LF);
         send_file(fq);
      end
      settle();

      apply_setting(33'd3, 33'd12);
      run_files(200);
      apply_setting(33'h1FF_FFFF, 33'h1_FFFF_FFFF);
      run_files(150);

      // Closing stretch at full rate on both sides
      apply_setting(33'd6, 33'd3);
      calm = 1'b1;
      run_files(200);

      foreach (pending_results[i])
         report_mismatch("missing result", 64'(pending_results[i].line_number), 64'd0);
      $display("Scanned %0d bytes in %0d files under %0d register settings.",
               bytes_sent, files_sent, settings_used);
      $display("Checked %0d line anchors and %0d file totals; %0d mismatches.",
               anchors_seen, totals_seen, mismatches);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
